// ===== rtl/lrct_pkg.sv =====
// Package: shared types and constants for the chunk residency table.
`default_nettype none
package lrct_pkg;
  localparam int unsigned Capacity = 32;
  localparam int unsigned CoordW = 32;
  localparam int unsigned StampW = 64;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned CountW = 6;

  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SPARE  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CoordW-1:0] chunk_x;
    logic [CoordW-1:0] chunk_y;
    logic [CoordW-1:0] chunk_z;
    logic              in_bounds;
  } req_t;

  typedef struct packed {
    logic              record_kind;
    logic              last;
    logic              ok;
    logic              was_hit;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] victim_x;
    logic [CoordW-1:0] victim_y;
    logic [CoordW-1:0] victim_z;
    logic [CountW-1:0] resident_count;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, reset scan
    logic scan_start; // restart slot scan
    logic scan_step;  // examine one slot
    logic halve;      // halve all stamps
    logic touch;      // stamp target slot
    logic evict;      // drop best victim
    logic insert;     // write request into free slot
    logic remove;     // drop hit slot
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free_found;
    logic clock_max;
    logic need_evict;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/lrct_if.sv =====
// Interface: valid/ready channel with a generic payload.
`default_nettype none
interface lrct_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrct_dp.sv =====
// Datapath: entry store, serial match/victim scan, access clock, counters.
`default_nettype none
module lrct_dp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lrct_pkg::cmd_t          cmd_i,
  input  wire lrct_pkg::req_t          req_i,
  input  wire logic [5:0]              limit_i,
  output lrct_pkg::sts_t               sts_o,
  output logic [lrct_pkg::SlotW-1:0]   hit_slot_o,
  output logic [lrct_pkg::SlotW-1:0]   free_slot_o,
  output logic [lrct_pkg::SlotW-1:0]   vic_slot_o,
  output logic [lrct_pkg::CoordW-1:0]  vic_x_o,
  output logic [lrct_pkg::CoordW-1:0]  vic_y_o,
  output logic [lrct_pkg::CoordW-1:0]  vic_z_o,
  output logic [lrct_pkg::CountW-1:0]  count_o
);
  localparam int unsigned Capacity = lrct_pkg::Capacity;
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CW   = lrct_pkg::CoordW;
  localparam int unsigned SW   = lrct_pkg::StampW;
  localparam int unsigned OW   = lrct_pkg::SlotW;

  logic [Capacity-1:0] valid_q;
  logic [CW-1:0] ex_q [Capacity];
  logic [CW-1:0] ey_q [Capacity];
  logic [CW-1:0] ez_q [Capacity];
  logic [SW-1:0] st_q [Capacity];
  logic [SW-1:0] clk_q;
  logic [CntW-1:0] occ_q;

  logic [CntW-1:0] idx_q;
  logic hit_q, free_q, vic_q;
  logic [IdxW-1:0] hit_s_q, free_s_q, vic_s_q;
  logic [SW-1:0] vst_q;
  logic [CW-1:0] vx_q, vy_q, vz_q;

  logic [IdxW-1:0] idx;
  logic            match, older;
  logic [CntW:0]   lim_ext;

  assign idx = idx_q[IdxW-1:0];
  assign match = valid_q[idx] && ex_q[idx] == req_i.chunk_x &&
                 ey_q[idx] == req_i.chunk_y && ez_q[idx] == req_i.chunk_z;

  // tie order: stamp, then signed x, y, z
  always_comb begin
    priority if (st_q[idx] != vst_q) begin
      older = st_q[idx] < vst_q;
    end else if (ex_q[idx] != vx_q) begin
      older = $signed(ex_q[idx]) < $signed(vx_q);
    end else if (ey_q[idx] != vy_q) begin
      older = $signed(ey_q[idx]) < $signed(vy_q);
    end else begin
      older = $signed(ez_q[idx]) < $signed(vz_q);
    end
  end

  // clamp limit to 1..Capacity
  always_comb begin
    lim_ext = {{(CntW+1-6){1'b0}}, limit_i};
    if (limit_i == 6'd0) lim_ext = (CntW+1)'(1);
    if (lim_ext > (CntW+1)'(Capacity)) lim_ext = (CntW+1)'(Capacity);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clk_q   <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.scan_start) begin
        idx_q  <= '0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
        if (cmd_i.load) hit_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (match && !hit_q) begin
          hit_q <= 1'b1;
          hit_s_q <= idx;
        end
        if (!valid_q[idx] && !free_q) begin
          free_q <= 1'b1;
          free_s_q <= idx;
        end
        if (valid_q[idx] && (!vic_q || older)) begin
          vic_q   <= 1'b1;
          vic_s_q <= idx;
          vst_q   <= st_q[idx];
          vx_q    <= ex_q[idx];
          vy_q    <= ey_q[idx];
          vz_q    <= ez_q[idx];
        end
      end
      if (cmd_i.halve) begin
        clk_q <= SW'(1);
      end else if (cmd_i.touch) begin
        clk_q <= clk_q + 1'b1;
      end
      if (cmd_i.evict) begin
        valid_q[vic_s_q] <= 1'b0;
        occ_q <= occ_q - 1'b1;
      end
      if (cmd_i.remove) begin
        valid_q[hit_s_q] <= 1'b0;
        occ_q <= occ_q - 1'b1;
      end
      if (cmd_i.insert) begin
        valid_q[free_s_q] <= 1'b1;
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  // payload store; halving shifts every stamp, touch then writes the target
  always_ff @(posedge clk_i) begin
    if (cmd_i.halve) begin
      for (int i = 0; i < Capacity; i++) st_q[i] <= st_q[i] >> 1;
    end
    if (cmd_i.insert) begin
      ex_q[free_s_q] <= req_i.chunk_x;
      ey_q[free_s_q] <= req_i.chunk_y;
      ez_q[free_s_q] <= req_i.chunk_z;
    end
    if (cmd_i.touch) begin
      // clock restarts at 1 when it wraps
      st_q[hit_q ? hit_s_q : free_s_q] <= cmd_i.halve ? SW'(1) : clk_q + 1'b1;
    end
  end

  assign sts_o.scan_done  = idx_q == CntW'(Capacity);
  assign sts_o.hit        = hit_q;
  assign sts_o.free_found = free_q;
  assign sts_o.clock_max  = &clk_q;
  assign sts_o.need_evict = ({1'b0, occ_q} >= lim_ext) && occ_q != '0;

  assign hit_slot_o  = hit_q ? OW'(hit_s_q) : '0;
  assign free_slot_o = OW'(free_s_q);
  assign vic_slot_o  = OW'(vic_s_q);
  assign vic_x_o     = vx_q;
  assign vic_y_o     = vy_q;
  assign vic_z_o     = vz_q;
  assign count_o     = lrct_pkg::CountW'(occ_q);
endmodule
`default_nettype wire

// ===== rtl/lrct_ctrl.sv =====
// Controller: request sequencing, eviction loop and output register.
`default_nettype none
module lrct_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output lrct_pkg::rec_t               out_data_o,
  input  wire lrct_pkg::req_t          req_i,
  output logic                         req_load_o,
  output lrct_pkg::cmd_t               cmd_o,
  input  wire lrct_pkg::sts_t          sts_i,
  input  wire logic [lrct_pkg::SlotW-1:0]  hit_slot_i,
  input  wire logic [lrct_pkg::SlotW-1:0]  free_slot_i,
  input  wire logic [lrct_pkg::SlotW-1:0]  vic_slot_i,
  input  wire logic [lrct_pkg::CoordW-1:0] vic_x_i,
  input  wire logic [lrct_pkg::CoordW-1:0] vic_y_i,
  input  wire logic [lrct_pkg::CoordW-1:0] vic_z_i,
  input  wire logic [lrct_pkg::CountW-1:0] count_i
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_EVICT  = 8'b0000_1000,
    S_RESCAN = 8'b0001_0000,
    S_TOUCH  = 8'b0010_0000,
    S_FINAL  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  lrct_pkg::rec_t rec_q, rec_d;
  logic out_v_q, out_v_d;
  logic ok_q, ok_d, ins_q, ins_d;
  lrct_pkg::req_e rt;

  assign rt = lrct_pkg::req_e'(req_i.req_type);
  assign in_ready_o  = state_q == S_IDLE;
  assign req_load_o  = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = rec_q;

  always_comb begin
    state_d = state_q;
    rec_d   = rec_q;
    out_v_d = out_v_q && !out_ready_i;
    ok_d    = ok_q;
    ins_d   = ins_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_load_o) begin
          cmd_o.load = 1'b1;
          ins_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
        else cmd_o.scan_step = 1'b1;
      end
      S_DECIDE: begin
        if (rt == lrct_pkg::REQ_REMOVE) begin
          if (sts_i.hit) cmd_o.remove = 1'b1;
          ok_d = sts_i.hit;
          state_d = S_FINAL;
        end else if (rt != lrct_pkg::REQ_ACCESS || !req_i.in_bounds) begin
          ok_d = (rt != lrct_pkg::REQ_ACCESS) && sts_i.hit;
          state_d = S_FINAL;
        end else if (sts_i.hit) begin
          ok_d = 1'b1;
          state_d = S_TOUCH;
        end else if (sts_i.need_evict) begin
          state_d = S_EVICT;
        end else if (sts_i.free_found) begin
          cmd_o.insert = 1'b1;
          ins_d = 1'b1;
          ok_d = 1'b1;
          state_d = S_TOUCH;
        end else begin
          ok_d = 1'b0;
          state_d = S_FINAL;
        end
      end
      S_EVICT: begin
        if (!out_v_q || out_ready_i) begin
          cmd_o.evict = 1'b1;
          out_v_d = 1'b1;
          rec_d = '0;
          rec_d.slot = vic_slot_i;
          rec_d.victim_x = vic_x_i;
          rec_d.victim_y = vic_y_i;
          rec_d.victim_z = vic_z_i;
          rec_d.resident_count = count_i - 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = S_RESCAN;
        end
      end
      S_RESCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
        else cmd_o.scan_step = 1'b1;
      end
      S_TOUCH: begin
        cmd_o.touch = 1'b1;
        cmd_o.halve = sts_i.clock_max;
        state_d = S_FINAL;
      end
      S_FINAL: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          rec_d = '0;
          rec_d.record_kind = 1'b1;
          rec_d.last = 1'b1;
          rec_d.ok = ok_q;
          rec_d.was_hit = sts_i.hit;
          rec_d.slot = ins_q ? free_slot_i : hit_slot_i;
          rec_d.resident_count = count_i;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      ok_q    <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      ok_q    <= ok_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end
endmodule
`default_nettype wire

// ===== rtl/lru_chunk_residency_table_core.sv =====
// Top level: LRU chunk residency table.
// A one-slot-per-cycle scan of the 32 entries precedes each outcome; each eviction
// adds a rescan, and a hit or insert adds a touch. One request at a time: the next
// transfers the cycle after the outcome loads. A held result register stalls
// eviction and outcome.
// Reset clears all valid bits, the access clock and the count; limit resets to 32.
`default_nettype none
module lru_chunk_residency_table_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lrct_if.sink      req_if,
  lrct_if.source    rec_if,
  lrct_if.sink      cfg_if
);
  logic [5:0] limit_q;
  lrct_pkg::req_t req_q;
  lrct_pkg::cmd_t cmd;
  lrct_pkg::sts_t sts;
  logic load;
  logic [lrct_pkg::SlotW-1:0] hs, fs, vs;
  logic [lrct_pkg::CoordW-1:0] vx, vy, vz;
  logic [lrct_pkg::CountW-1:0] cnt;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd32;
    end else if (cfg_if.valid) begin
      limit_q <= cfg_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) req_q <= req_if.data;
  end

  lrct_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid), .in_ready_o (req_if.ready),
    .out_valid_o (rec_if.valid), .out_ready_i (rec_if.ready),
    .out_data_o (rec_if.data),
    .req_i (req_q), .req_load_o (load), .cmd_o (cmd), .sts_i (sts),
    .hit_slot_i (hs), .free_slot_i (fs), .vic_slot_i (vs),
    .vic_x_i (vx), .vic_y_i (vy), .vic_z_i (vz), .count_i (cnt)
  );

  lrct_dp u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .req_i (req_q), .limit_i (limit_q),
    .sts_o (sts), .hit_slot_o (hs), .free_slot_o (fs), .vic_slot_o (vs),
    .vic_x_o (vx), .vic_y_o (vy), .vic_z_o (vz), .count_o (cnt)
  );
endmodule
`default_nettype wire

// ===== sim/tb_lru_chunk_residency_table_core.sv =====
// Testbench for the LRU chunk residency table: directed and random requests checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_lru_chunk_residency_table_core;
  localparam int unsigned Slots = lrct_pkg::Capacity;
  localparam int unsigned CW = lrct_pkg::CoordW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lrct_if #(.T(lrct_pkg::req_t)) req_ch ();
  lrct_if #(.T(lrct_pkg::rec_t)) rec_ch ();
  lrct_if #(.T(logic [5:0]))     cfg_ch ();

  lru_chunk_residency_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_ch),
    .rec_if (rec_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rec_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
  end

  // table shadow
  logic                        tbl_valid [Slots];
  logic [CW-1:0]               tbl_x [Slots];
  logic [CW-1:0]               tbl_y [Slots];
  logic [CW-1:0]               tbl_z [Slots];
  logic [lrct_pkg::StampW-1:0] tbl_stamp [Slots];
  logic [lrct_pkg::StampW-1:0] use_clock;
  int unsigned                 resident;
  logic [5:0]                  limit_reg;

  lrct_pkg::rec_t expected_recs[$];
  int   n_errors;
  int   n_reqs;
  int   n_recs;
  int   n_evicts;
  bit   steady;     // no random idling while set
  int   stall_left; // long receiver hold-off, counted by the receiver

  logic [CW-1:0] pool_x [16];
  logic [CW-1:0] pool_y [16];
  logic [CW-1:0] pool_z [16];

  function automatic lrct_pkg::rec_t make_rec(logic kind, logic ok, logic hit, int slot,
                                              logic [CW-1:0] vx, logic [CW-1:0] vy,
                                              logic [CW-1:0] vz);
    lrct_pkg::rec_t r;
    r.record_kind    = kind;
    r.last           = kind;
    r.ok             = ok;
    r.was_hit        = hit;
    r.slot           = slot[lrct_pkg::SlotW-1:0];
    r.victim_x       = vx;
    r.victim_y       = vy;
    r.victim_z       = vz;
    r.resident_count = resident[lrct_pkg::CountW-1:0];
    return r;
  endfunction

  function automatic void stamp_slot(int s);
    if (use_clock == '1) begin
      for (int i = 0; i < Slots; i++)
        if (tbl_valid[i]) tbl_stamp[i] = tbl_stamp[i] >> 1;
      use_clock = 1;
    end else begin
      use_clock = use_clock + 1;
    end
    tbl_stamp[s] = use_clock;
  endfunction

  function automatic bit older_than(int a, int b);
    if (tbl_stamp[a] != tbl_stamp[b]) return tbl_stamp[a] < tbl_stamp[b];
    if (tbl_x[a] != tbl_x[b]) return $signed(tbl_x[a]) < $signed(tbl_x[b]);
    if (tbl_y[a] != tbl_y[b]) return $signed(tbl_y[a]) < $signed(tbl_y[b]);
    return $signed(tbl_z[a]) < $signed(tbl_z[b]);
  endfunction

  // works out the records caused by one accepted request and updates the shadow
  function automatic void predict_records(lrct_pkg::req_t r);
    int unsigned lim;
    int hit;
    int victim;
    int free_slot;
    lim = limit_reg;
    hit = -1;
    free_slot = -1;
    if (lim == 0) lim = 1;
    if (lim > Slots) lim = Slots;
    for (int i = 0; i < Slots; i++)
      if (hit < 0 && tbl_valid[i] && tbl_x[i] == r.chunk_x && tbl_y[i] == r.chunk_y &&
          tbl_z[i] == r.chunk_z) hit = i;
    if (lrct_pkg::req_e'(r.req_type) == lrct_pkg::REQ_REMOVE) begin
      if (hit >= 0) begin
        tbl_valid[hit] = 1'b0;
        resident--;
      end
      expected_recs.push_back(make_rec(1, hit >= 0, hit >= 0, hit >= 0 ? hit : 0, 0, 0, 0));
    end else if (lrct_pkg::req_e'(r.req_type) != lrct_pkg::REQ_ACCESS || !r.in_bounds) begin
      expected_recs.push_back(make_rec(1,
                                       lrct_pkg::req_e'(r.req_type) != lrct_pkg::REQ_ACCESS
                                       && hit >= 0,
                                       hit >= 0, hit >= 0 ? hit : 0, 0, 0, 0));
    end else if (hit >= 0) begin
      stamp_slot(hit);
      expected_recs.push_back(make_rec(1, 1, 1, hit, 0, 0, 0));
    end else begin
      while (resident >= lim && resident > 0) begin
        victim = -1;
        for (int i = 0; i < Slots; i++)
          if (tbl_valid[i] && (victim < 0 || older_than(i, victim))) victim = i;
        tbl_valid[victim] = 1'b0;
        resident--;
        n_evicts++;
        expected_recs.push_back(make_rec(0, 0, 0, victim, tbl_x[victim], tbl_y[victim],
                                         tbl_z[victim]));
      end
      for (int i = Slots - 1; i >= 0; i--)
        if (!tbl_valid[i]) free_slot = i;
      if (free_slot < 0) begin
        expected_recs.push_back(make_rec(1, 0, 0, 0, 0, 0, 0));
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_x[free_slot] = r.chunk_x;
        tbl_y[free_slot] = r.chunk_y;
        tbl_z[free_slot] = r.chunk_z;
        tbl_stamp[free_slot] = '0;
        resident++;
        stamp_slot(free_slot);
        expected_recs.push_back(make_rec(1, 1, 0, free_slot, 0, 0, 0));
      end
    end
  endfunction

  // receiver side
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rec_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rec_ch.ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    lrct_pkg::rec_t got;
    lrct_pkg::rec_t want;
    if (rst_ni && rec_ch.valid && rec_ch.ready) begin
      got = rec_ch.data;
      n_recs++;
      if (expected_recs.size() == 0) begin
        $error("record transfer with nothing expected: %p", got);
        n_errors++;
      end else begin
        want = expected_recs.pop_front();
        check_field("record_kind", want.record_kind, got.record_kind);
        check_field("last", want.last, got.last);
        check_field("ok", want.ok, got.ok);
        check_field("was_hit", want.was_hit, got.was_hit);
        check_field("slot", want.slot, got.slot);
        check_field("victim_x", want.victim_x, got.victim_x);
        check_field("victim_y", want.victim_y, got.victim_y);
        check_field("victim_z", want.victim_z, got.victim_z);
        check_field("resident_count", want.resident_count, got.resident_count);
      end
    end
  end

  // valid stays high between back-to-back requests unless random idling lowers it; drain_table lowers it
  task automatic send_req(lrct_pkg::req_e kind, logic [CW-1:0] x, logic [CW-1:0] y,
                          logic [CW-1:0] z, logic inb);
    lrct_pkg::req_t r;
    r.req_type  = kind;
    r.chunk_x   = x;
    r.chunk_y   = y;
    r.chunk_z   = z;
    r.in_bounds = inb;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 38) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    n_reqs++;
    predict_records(r);
  endtask

  task automatic drain_table();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait (expected_recs.size() == 0);
  endtask

  task automatic write_limit(logic [5:0] v);
    drain_table();
    // quiet gap before the limit changes
    repeat (Slots + 10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    limit_reg = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_req();
    int p;
    int k;
    lrct_pkg::req_e kind;
    p = $urandom_range(15);
    k = $urandom_range(99);
    if (k < 60) kind = lrct_pkg::REQ_ACCESS;
    else if (k < 75) kind = lrct_pkg::REQ_LOOKUP;
    else if (k < 95) kind = lrct_pkg::REQ_REMOVE;
    else kind = lrct_pkg::REQ_SPARE;
    if ($urandom_range(9) == 0)
      send_req(kind, $urandom, $urandom, $urandom, $urandom_range(99) < 85);
    else
      send_req(kind, pool_x[p], pool_y[p], pool_z[p], $urandom_range(99) < 85);
  endtask

  task automatic test_basic_requests();
    send_req(lrct_pkg::REQ_ACCESS, 0, 0, 0, 1);           // miss, insert
    send_req(lrct_pkg::REQ_ACCESS, 0, 0, 0, 1);           // hit, touch
    send_req(lrct_pkg::REQ_LOOKUP, 0, 0, 0, 0);
    send_req(lrct_pkg::REQ_SPARE, 0, 0, 0, 1);            // behaves as lookup
    send_req(lrct_pkg::REQ_ACCESS, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    send_req(lrct_pkg::REQ_ACCESS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1);
    send_req(lrct_pkg::REQ_ACCESS, 5, 5, 5, 0);           // out of bounds miss
    send_req(lrct_pkg::REQ_ACCESS, 0, 0, 0, 0);           // out of bounds on resident entry
    send_req(lrct_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_req(lrct_pkg::REQ_LOOKUP, 1, 2, 3, 1);           // lookup miss
    send_req(lrct_pkg::REQ_REMOVE, 0, 0, 0, 1);
    send_req(lrct_pkg::REQ_REMOVE, 0, 0, 0, 1);           // remove of absent entry
    send_req(lrct_pkg::REQ_ACCESS, 9, 9, 9, 1);           // reuses lowest free slot
    send_req(lrct_pkg::REQ_SPARE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0);
    drain_table();
  endtask

  task automatic test_limit_extremes();
    write_limit(6'd1);                           // every new miss evicts
    send_req(lrct_pkg::REQ_ACCESS, 1, 1, 1, 1);
    send_req(lrct_pkg::REQ_ACCESS, -1, -1, -1, 1);
    write_limit(6'd0);                           // acts as one
    send_req(lrct_pkg::REQ_ACCESS, 2, 2, 2, 1);
    send_req(lrct_pkg::REQ_ACCESS, 2, 2, 2, 1);
    write_limit(6'd63);                          // acts as full capacity
    for (int i = 0; i < Slots + 1; i++)
      send_req(lrct_pkg::REQ_ACCESS, i * 7 - 50, -i, i, 1);
    send_req(lrct_pkg::REQ_ACCESS, 2, 2, 2, 1);
    write_limit(6'd3);                           // miss drops many entries at once
    send_req(lrct_pkg::REQ_ACCESS, 100, 100, 100, 1);
    drain_table();
  endtask

  task automatic test_random_mix(logic [5:0] lim, int count);
    write_limit(lim);
    for (int i = 0; i < count; i++) random_req();
    drain_table();
  endtask

  task automatic test_output_backpressure();
    steady = 1'b1;
    stall_left = 400;
    for (int i = 0; i < 8; i++) random_req();
    drain_table();
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_z[i] = '0;
      tbl_stamp[i] = '0;
    end
    use_clock = '0;
    resident = 0;
    limit_reg = 6'd32;
    n_errors = 0;
    n_reqs = 0;
    n_recs = 0;
    n_evicts = 0;
    steady = 1'b0;
    stall_left = 0;
    for (int i = 0; i < 16; i++) begin
      if (i < 4) begin
        pool_x[i] = $urandom;
        pool_y[i] = $urandom;
        pool_z[i] = $urandom;
      end else begin
        pool_x[i] = $urandom_range(6) - 3;
        pool_y[i] = $urandom_range(2) - 1;
        pool_z[i] = $urandom_range(2) - 1;
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_requests();
    test_limit_extremes();
    test_random_mix(6'd5, 20);
    steady = 1'b1;
    test_random_mix(6'd12, 15);
    steady = 1'b0;
    test_random_mix(6'd32, 15);
    test_output_backpressure();

    drain_table();
    repeat (3 * Slots + 20) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d records including %0d evictions,",
             n_reqs, n_recs, n_evicts);
    $display("over limits 1, 0, 63, 3, 5, 12 and 32 with random idling and a long hold-off.");
    if (n_errors == 0 && expected_recs.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_recs.size() != 0)
        $error("%0d expected records never arrived", expected_recs.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
